// ----- rtl/rarm_pkg.sv -----
// ----------------------------------------------------------------------------
// rarm_pkg
// Shared constants and controller/datapath interface types for the rational
// add/multiply/reduce unit.
// ----------------------------------------------------------------------------
package rarm_pkg;

	localparam int OPERAND_WIDTH_DEF = 16;

	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_NUM = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_DEN = 1'b1;

	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_MUL = 1'b1;

	typedef enum logic [1:0] {
		MUL_DEN,
		MUL_P1,
		MUL_P2
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     sum;
		logic     gcd_step;
		logic     div_init;
		logic     div_step;
		logic     out_load;
	} rarm_cmd_t;

	typedef struct packed {
		logic den_zero;
		logic is_add;
		logic num_zero;
		logic gcd_done;
		logic div_done;
		logic out_full;
	} rarm_sts_t;

endpackage

// ----- rtl/rarm_ctrl.sv -----
// ----------------------------------------------------------------------------
// rarm_ctrl
// Sequencer: operand capture, two or three products (three for add), sum,
// binary GCD loop, dual division loop and result write.
// ----------------------------------------------------------------------------
module rarm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rarm_pkg::rarm_sts_t sts,
	output rarm_pkg::rarm_cmd_t cmd
);

	typedef enum logic [2:0] {
		IDLE,
		MUL_D,
		MUL_A,
		MUL_B,
		SUM,
		GCD,
		DIV,
		WRITE
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == IDLE);

	always_comb begin
		cmd = '0;
		cmd.mul_sel = rarm_pkg::MUL_DEN;
		unique case (state_q)
			IDLE: begin
				cmd.load = in_valid;
			end
			MUL_D: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = rarm_pkg::MUL_DEN;
			end
			MUL_A: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = rarm_pkg::MUL_P1;
			end
			MUL_B: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = rarm_pkg::MUL_P2;
			end
			SUM: begin
				cmd.sum = 1'b1;
			end
			GCD: begin
				if (!sts.num_zero) begin
					cmd.div_init = sts.gcd_done;
					cmd.gcd_step = !sts.gcd_done;
				end
			end
			DIV: begin
				cmd.div_step = !sts.div_done;
			end
			WRITE: begin
				cmd.out_load = !sts.out_full;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (in_valid) state_q <= MUL_D;
				end
				MUL_D: begin
					state_q <= sts.den_zero ? WRITE : MUL_A;
				end
				MUL_A: begin
					state_q <= sts.is_add ? MUL_B : SUM;
				end
				MUL_B: begin
					state_q <= SUM;
				end
				SUM: begin
					state_q <= GCD;
				end
				GCD: begin
					if (sts.num_zero) state_q <= WRITE;
					else if (sts.gcd_done) state_q <= DIV;
				end
				DIV: begin
					if (sts.div_done) state_q <= WRITE;
				end
				WRITE: begin
					if (!sts.out_full) state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/rarm_dp.sv -----
// ----------------------------------------------------------------------------
// rarm_dp
// Datapath: shared multiplier, sum and magnitude, binary GCD, two restoring
// dividers run side by side, and the output register.
// ----------------------------------------------------------------------------
module rarm_dp #(
	parameter int OPERAND_WIDTH = rarm_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rarm_pkg::rarm_cmd_t             cmd,
	output rarm_pkg::rarm_sts_t             sts,
	input  logic                            command,
	input  logic signed [OPERAND_WIDTH-1:0] operand_numerator,
	input  logic        [OPERAND_WIDTH-1:0] operand_denominator,
	input  logic signed [OPERAND_WIDTH-1:0] stored_num,
	input  logic        [OPERAND_WIDTH-1:0] stored_den,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [2*OPERAND_WIDTH:0] result_numerator,
	output logic      [2*OPERAND_WIDTH-1:0] result_denominator,
	output logic                            error_flag
);

	localparam int W   = OPERAND_WIDTH;
	localparam int RW  = 2 * W;
	localparam int KW  = $clog2(RW);
	localparam int CW  = $clog2(RW + 1);

	logic                cmd_q;
	logic signed [W-1:0] on_q;
	logic        [W-1:0] od_q;

	logic signed [W:0]    mul_a, mul_b;
	logic signed [2*W+1:0] prod;

	logic        [RW-1:0] den_q;
	logic signed [RW:0]   p1_q, p2_q;
	logic signed [RW:0]   sum_v;
	logic        [RW-1:0] mag_q;
	logic                 neg_q;

	logic [RW-1:0] ga_q, gb_q;
	logic [KW-1:0] gk_q;
	logic [RW:0]   gdiff;

	logic [RW-1:0] dv_q, qa_q, qb_q, ra_q, rb_q;
	logic [CW-1:0] cnt_q;
	logic [RW:0]   ea, eb, ta, tb;

	logic out_valid_q;

	// shared multiplier, operands extended by one bit so all products are signed
	always_comb begin
		case (cmd.mul_sel)
			rarm_pkg::MUL_DEN: begin
				mul_a = {1'b0, od_q};
				mul_b = {1'b0, stored_den};
			end
			rarm_pkg::MUL_P1: begin
				mul_a = {on_q[W-1], on_q};
				mul_b = (cmd_q == rarm_pkg::CMD_ADD) ? {1'b0, stored_den}
					: {stored_num[W-1], stored_num};
			end
			rarm_pkg::MUL_P2: begin
				mul_a = {stored_num[W-1], stored_num};
				mul_b = {1'b0, od_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod  = mul_a * mul_b;
	assign sum_v = p1_q + p2_q;
	assign gdiff = {1'b0, ga_q} - {1'b0, gb_q};

	assign ea = {ra_q, qa_q[RW-1]};
	assign eb = {rb_q, qb_q[RW-1]};
	assign ta = ea - {1'b0, dv_q};
	assign tb = eb - {1'b0, dv_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= command;
			on_q  <= operand_numerator;
			od_q  <= operand_denominator;
			p2_q  <= '0;
		end
		if (cmd.mul_en) begin
			case (cmd.mul_sel)
				rarm_pkg::MUL_DEN: den_q <= prod[RW-1:0];
				rarm_pkg::MUL_P1:  p1_q  <= prod[RW:0];
				rarm_pkg::MUL_P2:  p2_q  <= prod[RW:0];
				default: ;
			endcase
		end
		if (cmd.sum) begin
			neg_q <= sum_v[RW];
			mag_q <= sum_v[RW] ? RW'(-sum_v) : sum_v[RW-1:0];
			ga_q  <= sum_v[RW] ? RW'(-sum_v) : sum_v[RW-1:0];
			gb_q  <= den_q;
			gk_q  <= '0;
		end
		if (cmd.gcd_step) begin
			if (!ga_q[0] && !gb_q[0]) begin
				ga_q <= ga_q >> 1;
				gb_q <= gb_q >> 1;
				gk_q <= gk_q + KW'(1);
			end else if (!ga_q[0]) begin
				ga_q <= ga_q >> 1;
			end else if (!gb_q[0]) begin
				gb_q <= gb_q >> 1;
			end else if (gdiff[RW]) begin
				gb_q <= RW'(-gdiff);
			end else begin
				ga_q <= gdiff[RW-1:0];
			end
		end
		if (cmd.div_init) begin
			dv_q <= ga_q << gk_q;
			qa_q <= mag_q;
			qb_q <= den_q;
			ra_q <= '0;
			rb_q <= '0;
		end
		if (cmd.div_step) begin
			ra_q <= ta[RW] ? ea[RW-1:0] : ta[RW-1:0];
			rb_q <= tb[RW] ? eb[RW-1:0] : tb[RW-1:0];
			qa_q <= {qa_q[RW-2:0], !ta[RW]};
			qb_q <= {qb_q[RW-2:0], !tb[RW]};
		end
		if (cmd.out_load) begin
			if (sts.den_zero) begin
				result_numerator   <= '0;
				result_denominator <= '0;
				error_flag         <= 1'b1;
			end else if (sts.num_zero) begin
				result_numerator   <= '0;
				result_denominator <= RW'(1);
				error_flag         <= 1'b0;
			end else begin
				result_numerator   <= neg_q ? -$signed({1'b0, qa_q}) : $signed({1'b0, qa_q});
				result_denominator <= qb_q;
				error_flag         <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.div_init) cnt_q <= CW'(RW);
			else if (cmd.div_step) cnt_q <= cnt_q - CW'(1);
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		sts.den_zero = (od_q == '0) || (stored_den == '0);
		sts.is_add   = (cmd_q == rarm_pkg::CMD_ADD);
		sts.num_zero = (mag_q == '0);
		sts.gcd_done = (ga_q == gb_q);
		sts.div_done = (cnt_q == '0);
		sts.out_full = out_valid_q && !out_ready;
	end

endmodule

// ----- rtl/rational_add_multiply_reduce_unit.sv -----
// ----------------------------------------------------------------------------
// rational_add_multiply_reduce_unit
// Adds an operand fraction to, or multiplies it by, the stored fraction and
// returns the result reduced to lowest terms.
// ----------------------------------------------------------------------------
// One item is processed at a time; a finished result sits in the output
// register so the next item can be taken while it waits. With W the operand
// width, the binary GCD loop does one shift or subtract per cycle, and the
// 2W-step division divides numerator and denominator side by side. A zero
// denominator returns 0/0 with error_flag set; a zero result returns 0/1.
module rational_add_multiply_reduce_unit #(
	parameter int OPERAND_WIDTH = rarm_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [rarm_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [OPERAND_WIDTH-1:0]            cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                command,
	input  logic signed [OPERAND_WIDTH-1:0]     operand_numerator,
	input  logic        [OPERAND_WIDTH-1:0]     operand_denominator,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [2*OPERAND_WIDTH:0]     result_numerator,
	output logic        [2*OPERAND_WIDTH-1:0]   result_denominator,
	output logic                                error_flag
);

	logic signed [OPERAND_WIDTH-1:0] stored_num_q;
	logic        [OPERAND_WIDTH-1:0] stored_den_q;

	rarm_pkg::rarm_cmd_t cmd;
	rarm_pkg::rarm_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_num_q <= '0;
			stored_den_q <= OPERAND_WIDTH'(1);
		end else if (cfg_write) begin
			unique case (cfg_index)
				rarm_pkg::REG_NUM: stored_num_q <= cfg_data;
				rarm_pkg::REG_DEN: stored_den_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rarm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rarm_dp #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.command             (command),
		.operand_numerator   (operand_numerator),
		.operand_denominator (operand_denominator),
		.stored_num          (stored_num_q),
		.stored_den          (stored_den_q),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.result_numerator    (result_numerator),
		.result_denominator  (result_denominator),
		.error_flag          (error_flag)
	);

endmodule

// ----- tb/rational_add_multiply_reduce_unit_tb.sv -----
// ----------------------------------------------------------------------------
// rational_add_multiply_reduce_unit_tb
// Self-checking regression for the rational add/multiply/reduce unit. The
// stored fraction is loaded through the register port between phases. Add and
// multiply commands go in over a valid/ready channel. Each reduced result is
// compared with a fraction worked out in the bench. Both sides idle at random.
// The receiver also holds off long enough to back the unit up.
// ----------------------------------------------------------------------------
module rational_add_multiply_reduce_unit_tb;

	localparam int W = rarm_pkg::OPERAND_WIDTH_DEF;
	localparam int NW = 2 * W + 1;
	localparam int DW = 2 * W;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 150;
	localparam int LONG_HOLD_CYCLES = 400;

	typedef struct {
		logic signed [2*W:0]  num;
		logic        [2*W-1:0] den;
		logic                  err;
	} fraction_t;

	class fraction_scoreboard;
		logic signed [W-1:0] stored_num;
		logic        [W-1:0] stored_den;
		fraction_t           expected_fractions[$];
		int                  errors;

		function new();
			stored_num = '0;
			stored_den = 1;
			errors = 0;
		endfunction

		function void set_register(logic [rarm_pkg::REG_IDX_W-1:0] idx, logic [W-1:0] value);
			if (idx == rarm_pkg::REG_NUM) begin
				stored_num = value;
			end else begin
				stored_den = value;
			end
		endfunction

		function fraction_t predict_fraction(logic cmd, logic signed [W-1:0] on,
				logic [W-1:0] od);
			fraction_t r;
			longint num;
			longint mag;
			longint den;
			longint a;
			longint b;
			longint t;
			if (od == 0 || stored_den == 0) begin
				r.num = '0;
				r.den = '0;
				r.err = 1'b1;
				return r;
			end
			den = longint'(od) * longint'(stored_den);
			if (cmd == rarm_pkg::CMD_ADD) begin
				num = longint'(on) * longint'(stored_den) + longint'(stored_num) * longint'(od);
			end else begin
				num = longint'(on) * longint'(stored_num);
			end
			r.err = 1'b0;
			if (num == 0) begin
				r.num = '0;
				r.den = 1;
				return r;
			end
			mag = (num < 0) ? -num : num;
			a = mag;
			b = den;
			while (b != 0) begin
				t = a % b;
				a = b;
				b = t;
			end
			mag = mag / a;
			den = den / a;
			r.num = NW'((num < 0) ? -mag : mag);
			r.den = DW'(den);
			return r;
		endfunction

		function void record_operation(logic cmd, logic signed [W-1:0] on, logic [W-1:0] od);
			expected_fractions.push_back(predict_fraction(cmd, on, od));
		endfunction

		function void check_result(logic signed [2*W:0] num, logic [2*W-1:0] den, logic err);
			fraction_t e;
			if (expected_fractions.size() == 0) begin
				$display("%0t: unexpected result %0d/%0d err %0b", $time, num, den, err);
				errors++;
				return;
			end
			e = expected_fractions.pop_front();
			if (num !== e.num) begin
				$display("%0t: result_numerator expected %0d actual %0d", $time, e.num, num);
				errors++;
			end
			if (den !== e.den) begin
				$display("%0t: result_denominator expected %0d actual %0d", $time, e.den, den);
				errors++;
			end
			if (err !== e.err) begin
				$display("%0t: error_flag expected %0b actual %0b", $time, e.err, err);
				errors++;
			end
		endfunction

		function int pending();
			return expected_fractions.size();
		endfunction
	endclass

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_write = 1'b0;
	logic [rarm_pkg::REG_IDX_W-1:0]   cfg_index = rarm_pkg::REG_NUM;
	logic [W-1:0]                     cfg_data = '0;
	logic                             in_valid = 1'b0;
	logic                             in_ready;
	logic                             command = rarm_pkg::CMD_ADD;
	logic signed [W-1:0]              operand_numerator = '0;
	logic        [W-1:0]              operand_denominator = 1;
	logic                             out_valid;
	logic                             out_ready = 1'b0;
	logic signed [2*W:0]              result_numerator;
	logic        [2*W-1:0]            result_denominator;
	logic                             error_flag;

	fraction_scoreboard sb;
	bit  sender_idle = 1'b1;
	bit  receiver_idle = 1'b1;
	bit  long_hold_req = 1'b0;
	int  cycles = 0;

	rational_add_multiply_reduce_unit #(.OPERAND_WIDTH(W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.operand_numerator(operand_numerator),
		.operand_denominator(operand_denominator),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_numerator(result_numerator),
		.result_denominator(result_denominator),
		.error_flag(error_flag)
	);

	always #10 clk = ~clk;

	task automatic write_register(input logic [rarm_pkg::REG_IDX_W-1:0] idx,
			input logic [W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		sb.set_register(idx, value);
	endtask

	task automatic configure(input logic [W-1:0] num, input logic [W-1:0] den);
		write_register(rarm_pkg::REG_NUM, num);
		write_register(rarm_pkg::REG_DEN, den);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_item(input logic cmd, input logic signed [W-1:0] on,
			input logic [W-1:0] od);
		in_valid <= 1'b1;
		command <= cmd;
		operand_numerator <= on;
		operand_denominator <= od;
		do @(posedge clk); while (!in_ready);
		sb.record_operation(cmd, on, od);
		if (sender_idle && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// drop valid and let every outstanding transfer come back
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic random_item();
		logic                cmd;
		logic signed [W-1:0] on;
		logic        [W-1:0] od;
		cmd = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 15))
			0: od = '0;
			1, 2, 3, 4: od = W'($urandom_range(1, 16));
			5: od = '1;
			default: od = W'($urandom);
		endcase
		case ($urandom_range(0, 15))
			0: begin
				case ($urandom_range(0, 4))
					0: on = {1'b1, {(W-1){1'b0}}};
					1: on = {1'b0, {(W-1){1'b1}}};
					2: on = '0;
					3: on = '1;
					default: on = 1;
				endcase
			end
			1, 2, 3, 4: on = W'($urandom_range(0, 32) - 16);
			5: begin
				// sum cancels to zero
				cmd = rarm_pkg::CMD_ADD;
				on = -sb.stored_num;
				od = sb.stored_den;
			end
			default: on = W'($urandom);
		endcase
		send_item(cmd, on, od);
	endtask

	task automatic run_phase(input logic [W-1:0] num, input logic [W-1:0] den,
			input int count, input bit with_hold, input bit with_pause);
		configure(num, den);
		for (int i = 0; i < count; i++) begin
			if (with_hold && i == 10) begin
				long_hold_req = 1'b1;
			end
			if (with_pause && i == count / 2) begin
				wait_idle();
			end
			random_item();
		end
		wait_idle();
	endtask

	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				sb.check_result(result_numerator, result_denominator, error_flag);
			end
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left = LONG_HOLD_CYCLES;
			end else if (stall_left == 0 && receiver_idle && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 9);
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("rational_add_multiply_reduce_unit regression: fail");
		$finish;
	end

	initial begin
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset fraction 0/1
		send_item(rarm_pkg::CMD_ADD, 5, 10);
		send_item(rarm_pkg::CMD_MUL, -7, 3);
		send_item(rarm_pkg::CMD_ADD, 0, 1);
		send_item(rarm_pkg::CMD_ADD, -32768, 1);
		send_item(rarm_pkg::CMD_ADD, 32767, 16'hFFFF);
		send_item(rarm_pkg::CMD_MUL, 9, 0);
		wait_idle();

		configure(16'h8000, 16'hFFFF);
		send_item(rarm_pkg::CMD_ADD, -32768, 16'hFFFF);
		send_item(rarm_pkg::CMD_ADD, 32767, 1);
		send_item(rarm_pkg::CMD_MUL, -32768, 16'hFFFF);
		send_item(rarm_pkg::CMD_MUL, 32767, 1);
		send_item(rarm_pkg::CMD_ADD, 0, 0);
		send_item(rarm_pkg::CMD_MUL, 1, 1);
		wait_idle();

		configure(16'h7FFF, 1);
		send_item(rarm_pkg::CMD_ADD, -32767, 1);
		send_item(rarm_pkg::CMD_MUL, -1, 2);
		send_item(rarm_pkg::CMD_ADD, 32767, 16'hFFFF);
		send_item(rarm_pkg::CMD_MUL, 32767, 16'hFFFF);
		wait_idle();

		// zero stored denominator
		configure(1, 0);
		send_item(rarm_pkg::CMD_ADD, 1, 1);
		send_item(rarm_pkg::CMD_MUL, 5, 3);
		wait_idle();

		run_phase(W'($urandom), W'($urandom_range(1, 16'hFFFF)), 250, 1'b1, 1'b0);
		run_phase(16'h8000, 1, 180, 1'b0, 1'b1);
		run_phase(16'h7FFF, 16'hFFFF, 180, 1'b0, 1'b0);
		run_phase(0, 1, 120, 1'b1, 1'b0);
		run_phase(W'($urandom), W'($urandom_range(1, 16'hFFFF)), 250, 1'b0, 1'b1);
		run_phase(1, 0, 40, 1'b0, 1'b0);
		run_phase(W'($urandom_range(0, 32) - 16), W'($urandom_range(1, 16)), 200,
			1'b0, 1'b0);
		sender_idle = 1'b0;
		receiver_idle = 1'b0;
		run_phase(W'($urandom), W'($urandom_range(1, 16'hFFFF)), 180, 1'b0, 1'b0);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("rational_add_multiply_reduce_unit regression: pass");
		end else begin
			$display("rational_add_multiply_reduce_unit regression: fail");
		end
		$finish;
	end

endmodule
